// ===== src/point_orthogonal_projection_macros.svh =====
// Assertion macros for the point orthogonal projection block
`ifndef POINT_ORTHOGONAL_PROJECTION_MACROS_SVH
`define POINT_ORTHOGONAL_PROJECTION_MACROS_SVH
`ifndef SYNTHESIS
`define POP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define POP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define POP_ASSERT_SAME(lbl, ante, cons, msg)
`define POP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/pop_pkg.sv =====
// Shared types and constants for the point orthogonal projection block
`default_nettype none
package pop_pkg;

  localparam int NLANE = 3;

  typedef enum logic {
    ACT_LINE  = 1'b0,
    ACT_PLANE = 1'b1
  } act_t;

  // pipeline control handed to the divider
  typedef struct packed {
    logic en;
    logic vld;
  } pop_ctl_t;

endpackage
`default_nettype wire

// ===== src/pop_div.sv =====
// Three-lane pipelined restoring divider, one quotient bit per stage
`default_nettype none
module pop_div
  import pop_pkg::*;
#(
  parameter int DEN_W = 64,
  parameter int QUO_W = 68,
  parameter int MAG_W = 100
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pop_ctl_t                          ctl,
  input  logic [NLANE-1:0][MAG_W-1:0]       mag,
  input  logic [DEN_W-1:0]                  den,
  output logic [NLANE-1:0][QUO_W-1:0]       quo,
  output logic [NLANE-1:0][DEN_W-1:0]       rem,
  output logic [DEN_W-1:0]                  den_out,
  output logic                              vld
);

  localparam int HW = MAG_W - QUO_W;

  logic [NLANE-1:0][DEN_W-1:0] rem_in  [QUO_W];
  logic [NLANE-1:0][QUO_W-1:0] quo_in  [QUO_W];
  logic [DEN_W-1:0]            den_in  [QUO_W];
  logic [NLANE-1:0][DEN_W-1:0] rem_nxt [QUO_W];
  logic [NLANE-1:0][QUO_W-1:0] quo_nxt [QUO_W];
  logic [NLANE-1:0][DEN_W-1:0] rem_r   [QUO_W];
  logic [NLANE-1:0][QUO_W-1:0] quo_r   [QUO_W];
  logic [DEN_W-1:0]            den_r   [QUO_W];
  logic [QUO_W-1:0]            vld_r;

  // stage inputs: the top part of the dividend seeds the remainder
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      rem_in[0][l] = {{(DEN_W-HW){1'b0}}, mag[l][MAG_W-1:QUO_W]};
      quo_in[0][l] = mag[l][QUO_W-1:0];
    end
    den_in[0] = den;
    for (int k = 1; k < QUO_W; k++) begin
      rem_in[k] = rem_r[k-1];
      quo_in[k] = quo_r[k-1];
      den_in[k] = den_r[k-1];
    end
  end

  // low dividend bits shift out the top while quotient bits shift in below
  always_comb begin
    logic [DEN_W:0] t;
    logic [DEN_W:0] dif;
    logic           ge;
    for (int k = 0; k < QUO_W; k++) begin
      for (int l = 0; l < NLANE; l++) begin
        t   = {rem_in[k][l], quo_in[k][l][QUO_W-1]};
        dif = t - {1'b0, den_in[k]};
        ge  = (t >= {1'b0, den_in[k]});
        rem_nxt[k][l] = ge ? dif[DEN_W-1:0] : t[DEN_W-1:0];
        quo_nxt[k][l] = {quo_in[k][l][QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.en) begin
      vld_r <= {vld_r[QUO_W-2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= den_in[k];
      end
    end
  end

  assign quo     = quo_r[QUO_W-1];
  assign rem     = rem_r[QUO_W-1];
  assign den_out = den_r[QUO_W-1];
  assign vld     = vld_r[QUO_W-1];

endmodule
`default_nettype wire

// ===== src/point_orthogonal_projection.sv =====
// Top level: streaming projection of a point onto a line or a plane
//
//  channel | direction | transfer when        | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in_     | input     | in_valid & in_ready | action, point, vector, base, plane offset
//  out_    | output    | out_valid&out_ready | projected point, degenerate, saturated
//
// One transfer per cycle in and out at full rate while the skid is empty and out_ready holds.
// An input passes stages a to h, the bit-per-stage divider (NW quotient bits,
// NW = max(2*COORD_WIDTH, COORD_WIDTH+FRAC_BITS) + 4), stages i..k, output reg.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
// A stalled output fills a one-entry skid register, which freezes the whole pipeline
// on the next cycle; nothing is dropped or repeated.
`default_nettype none
`include "point_orthogonal_projection_macros.svh"
module point_orthogonal_projection
  import pop_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic signed [COORD_WIDTH-1:0] in_pt_x,
  input  logic signed [COORD_WIDTH-1:0] in_pt_y,
  input  logic signed [COORD_WIDTH-1:0] in_pt_z,
  input  logic signed [COORD_WIDTH-1:0] in_vec_a,
  input  logic signed [COORD_WIDTH-1:0] in_vec_b,
  input  logic signed [COORD_WIDTH-1:0] in_vec_c,
  input  logic signed [COORD_WIDTH-1:0] in_base_x,
  input  logic signed [COORD_WIDTH-1:0] in_base_y,
  input  logic signed [COORD_WIDTH-1:0] in_base_z,
  input  logic signed [COORD_WIDTH-1:0] in_plane_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_proj_x,
  output logic signed [COORD_WIDTH-1:0] out_proj_y,
  output logic signed [COORD_WIDTH-1:0] out_proj_z,
  output logic                          out_degenerate,
  output logic                          out_saturated
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int NL  = NLANE;
  // numerator width: covers v.(p-base) and v.p + d*2^F with headroom for the negation
  localparam int NW  = ((2*W > W+F) ? 2*W : W+F) + 4;
  localparam int DW  = 2*W;            // |v|^2, unsigned
  localparam int PW  = W + NW;         // v_i * num
  localparam int H   = NW / 2;         // split point of num for the two partial products
  localparam int LW  = W + H + 1;
  localparam int HIW = W + NW - H;
  localparam int SW  = NW + 2;         // org +/- quotient
  localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic en;

  // ---------------------------------------------------------------- stage a: capture
  logic                     a_vld_r, a_pl_r;
  logic [NL-1:0][W-1:0]     a_p_r, a_v_r, a_b_r;
  logic [W-1:0]             a_d_r;

  // ---------------------------------------------------------------- stage b: squares, p - base
  logic                     b_vld_r, b_pl_r;
  logic [NL-1:0][W-1:0]     b_p_r, b_v_r, b_org_r, b_org_nxt;
  logic [NL-1:0][W:0]       b_dif_r, b_dif_nxt;
  logic [NL-1:0][DW-1:0]    b_sq_r, b_sq_nxt;
  logic [NW-1:0]            b_dsh_r, b_dsh_nxt;

  // ---------------------------------------------------------------- stage c: |v|^2, dot terms
  logic                     c_vld_r, c_pl_r;
  logic [NL-1:0][W-1:0]     c_p_r, c_v_r, c_org_r;
  logic [DW-1:0]            c_den_r, c_den_nxt;
  logic [NL-1:0][2*W:0]     c_prod_r, c_prod_nxt;
  logic [NW-1:0]            c_dsh_r;

  // ---------------------------------------------------------------- stage d: dot sum
  logic                     d_vld_r, d_pl_r;
  logic [NL-1:0][W-1:0]     d_p_r, d_v_r, d_org_r;
  logic [DW-1:0]            d_den_r;
  logic [NW-1:0]            d_sum_r, d_sum_nxt;

  // ---------------------------------------------------------------- stage e: numerator
  logic                     e_vld_r, e_degen_r;
  logic [NL-1:0][W-1:0]     e_p_r, e_v_r, e_org_r;
  logic [DW-1:0]            e_den_r;
  logic [NW-1:0]            e_num_r;

  // ---------------------------------------------------------------- stage f: partial products
  logic                     f_vld_r, f_degen_r;
  logic [NL-1:0][W-1:0]     f_p_r, f_org_r;
  logic [DW-1:0]            f_den_r;
  logic [NL-1:0][LW-1:0]    f_lo_r, f_lo_nxt;
  logic [NL-1:0][HIW-1:0]   f_hi_r, f_hi_nxt;

  // ---------------------------------------------------------------- stage g: v_i * num
  logic                     g_vld_r, g_degen_r;
  logic [NL-1:0][W-1:0]     g_p_r, g_org_r;
  logic [DW-1:0]            g_den_r;
  logic [NL-1:0][PW-1:0]    g_prod_r, g_prod_nxt;

  // ---------------------------------------------------------------- stage h: sign / magnitude
  logic                     h_vld_r, h_degen_r;
  logic [NL-1:0][W-1:0]     h_p_r, h_org_r;
  logic [DW-1:0]            h_den_r;
  logic [NL-1:0]            h_neg_r;
  logic [NL-1:0][PW-1:0]    h_mag_r, h_mag_nxt;

  // ---------------------------------------------------------------- divider and side line
  pop_ctl_t                 dv_ctl;
  logic [NL-1:0][NW-1:0]    dv_quo;
  logic [NL-1:0][DW-1:0]    dv_rem;
  logic [DW-1:0]            dv_den;
  logic                     dv_vld;

  logic [NL-1:0][W-1:0]     s_p_r   [NW];
  logic [NL-1:0][W-1:0]     s_org_r [NW];
  logic [NL-1:0]            s_neg_r [NW];
  logic [NW-1:0]            s_degen_r;

  // ---------------------------------------------------------------- stages i..k: round, add, clamp
  logic                     i_vld_r, i_degen_r;
  logic [NL-1:0][W-1:0]     i_p_r, i_org_r;
  logic [NL-1:0]            i_neg_r;
  logic [NL-1:0][NW-1:0]    i_qr_r, i_qr_nxt;

  logic                     j_vld_r, j_degen_r;
  logic [NL-1:0][W-1:0]     j_p_r;
  logic [NL-1:0][SW-1:0]    j_sum_r, j_sum_nxt;

  logic                     k_vld_r, k_degen_r, k_sat_r, k_sat_nxt;
  logic [NL-1:0][W-1:0]     k_proj_r, k_proj_nxt;

  // ---------------------------------------------------------------- output and skid
  logic                     o_vld_r, o_vld_nxt, o_degen_r, o_sat_r;
  logic [NL-1:0][W-1:0]     o_proj_r;
  logic                     sk_vld_r, sk_vld_nxt, sk_degen_r, sk_sat_r;
  logic [NL-1:0][W-1:0]     sk_proj_r;
  logic                     push, take, ld_tail, ld_skid, sk_ld;

  // The whole pipeline moves together; only a full skid register holds it.
  assign en       = !sk_vld_r;
  assign in_ready = en;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
      j_vld_r <= 1'b0;
      k_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
      g_vld_r <= f_vld_r;
      h_vld_r <= g_vld_r;
      i_vld_r <= dv_vld;
      j_vld_r <= i_vld_r;
      k_vld_r <= j_vld_r;
    end
  end

  // stage b: plane mode uses p itself as the difference and as the origin
  always_comb begin
    logic signed [DW-1:0] sq;
    for (int i = 0; i < NL; i++) begin
      sq           = $signed(a_v_r[i]) * $signed(a_v_r[i]);
      b_sq_nxt[i]  = sq;
      b_dif_nxt[i] = a_pl_r ? {a_p_r[i][W-1], a_p_r[i]}
                            : ({a_p_r[i][W-1], a_p_r[i]} - {a_b_r[i][W-1], a_b_r[i]});
      b_org_nxt[i] = a_pl_r ? a_p_r[i] : a_b_r[i];
    end
    // d is scaled to the product's Q format
    b_dsh_nxt = a_pl_r ? ({{(NW-W){a_d_r[W-1]}}, a_d_r} << F) : '0;
  end

  // stage c
  always_comb begin
    logic signed [2*W:0] pf;
    for (int i = 0; i < NL; i++) begin
      pf            = $signed(b_v_r[i]) * $signed(b_dif_r[i]);
      c_prod_nxt[i] = pf;
    end
    c_den_nxt = b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
  end

  // stage d
  always_comb begin
    d_sum_nxt = c_dsh_r;
    for (int i = 0; i < NL; i++) begin
      d_sum_nxt = d_sum_nxt + {{(NW-2*W-1){c_prod_r[i][2*W]}}, c_prod_r[i]};
    end
  end

  // stage f: v_i * num as unsigned low half and signed high half
  always_comb begin
    logic signed [LW-1:0]  lo;
    logic signed [HIW-1:0] hi;
    for (int i = 0; i < NL; i++) begin
      lo          = $signed(e_v_r[i]) * $signed({1'b0, e_num_r[H-1:0]});
      hi          = $signed(e_v_r[i]) * $signed(e_num_r[NW-1:H]);
      f_lo_nxt[i] = lo;
      f_hi_nxt[i] = hi;
    end
  end

  // stages g and h
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      g_prod_nxt[i] = {f_hi_r[i], {H{1'b0}}} + {{(PW-LW){f_lo_r[i][LW-1]}}, f_lo_r[i]};
      h_mag_nxt[i]  = g_prod_r[i][PW-1] ? (PW'(0) - g_prod_r[i]) : g_prod_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pl_r    <= (in_action == ACT_PLANE);
      a_p_r[0]  <= in_pt_x;
      a_p_r[1]  <= in_pt_y;
      a_p_r[2]  <= in_pt_z;
      a_v_r[0]  <= in_vec_a;
      a_v_r[1]  <= in_vec_b;
      a_v_r[2]  <= in_vec_c;
      a_b_r[0]  <= in_base_x;
      a_b_r[1]  <= in_base_y;
      a_b_r[2]  <= in_base_z;
      a_d_r     <= in_plane_offset;

      b_pl_r    <= a_pl_r;
      b_p_r     <= a_p_r;
      b_v_r     <= a_v_r;
      b_org_r   <= b_org_nxt;
      b_dif_r   <= b_dif_nxt;
      b_sq_r    <= b_sq_nxt;
      b_dsh_r   <= b_dsh_nxt;

      c_pl_r    <= b_pl_r;
      c_p_r     <= b_p_r;
      c_v_r     <= b_v_r;
      c_org_r   <= b_org_r;
      c_den_r   <= c_den_nxt;
      c_prod_r  <= c_prod_nxt;
      c_dsh_r   <= b_dsh_r;

      d_pl_r    <= c_pl_r;
      d_p_r     <= c_p_r;
      d_v_r     <= c_v_r;
      d_org_r   <= c_org_r;
      d_den_r   <= c_den_r;
      d_sum_r   <= d_sum_nxt;

      // plane mode projects along -(n.p + d)
      e_degen_r <= (d_den_r == '0);
      e_p_r     <= d_p_r;
      e_v_r     <= d_v_r;
      e_org_r   <= d_org_r;
      e_den_r   <= d_den_r;
      e_num_r   <= d_pl_r ? (NW'(0) - d_sum_r) : d_sum_r;

      f_degen_r <= e_degen_r;
      f_p_r     <= e_p_r;
      f_org_r   <= e_org_r;
      f_den_r   <= e_den_r;
      f_lo_r    <= f_lo_nxt;
      f_hi_r    <= f_hi_nxt;

      g_degen_r <= f_degen_r;
      g_p_r     <= f_p_r;
      g_org_r   <= f_org_r;
      g_den_r   <= f_den_r;
      g_prod_r  <= g_prod_nxt;

      h_degen_r <= g_degen_r;
      h_p_r     <= g_p_r;
      h_org_r   <= g_org_r;
      h_den_r   <= g_den_r;
      for (int i = 0; i < NL; i++) begin
        h_neg_r[i] <= g_prod_r[i][PW-1];
      end
      h_mag_r   <= h_mag_nxt;
    end
  end

  // |v_i * num| / |v|^2, one quotient bit per stage
  assign dv_ctl.en  = en;
  assign dv_ctl.vld = h_vld_r;

  pop_div #(
    .DEN_W (DW),
    .QUO_W (NW),
    .MAG_W (PW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (dv_ctl),
    .mag     (h_mag_r),
    .den     (h_den_r),
    .quo     (dv_quo),
    .rem     (dv_rem),
    .den_out (dv_den),
    .vld     (dv_vld)
  );

  // side data runs next to the divider, same depth
  always_ff @(posedge clk) begin
    if (en) begin
      s_p_r[0]     <= h_p_r;
      s_org_r[0]   <= h_org_r;
      s_neg_r[0]   <= h_neg_r;
      s_degen_r[0] <= h_degen_r;
      for (int k = 1; k < NW; k++) begin
        s_p_r[k]     <= s_p_r[k-1];
        s_org_r[k]   <= s_org_r[k-1];
        s_neg_r[k]   <= s_neg_r[k-1];
        s_degen_r[k] <= s_degen_r[k-1];
      end
    end
  end

  // stage i: round half away from zero on the magnitude
  // stage j: apply the sign and add the origin
  // stage k: clamp; a degenerate vector passes the point through
  always_comb begin
    logic                 half;
    logic signed [SW-1:0] s;
    for (int i = 0; i < NL; i++) begin
      half        = ({dv_rem[i], 1'b0} >= {1'b0, dv_den});
      i_qr_nxt[i] = dv_quo[i] + NW'(half);
      j_sum_nxt[i] = i_neg_r[i]
                   ? ({{(SW-W){i_org_r[i][W-1]}}, i_org_r[i]} - {2'b00, i_qr_r[i]})
                   : ({{(SW-W){i_org_r[i][W-1]}}, i_org_r[i]} + {2'b00, i_qr_r[i]});
    end
    k_sat_nxt = 1'b0;
    for (int i = 0; i < NL; i++) begin
      s = $signed(j_sum_r[i]);
      if (j_degen_r) begin
        k_proj_nxt[i] = j_p_r[i];
      end else if (s > MAXV) begin
        k_proj_nxt[i] = MAXV[W-1:0];
        k_sat_nxt     = 1'b1;
      end else if (s < MINV) begin
        k_proj_nxt[i] = MINV[W-1:0];
        k_sat_nxt     = 1'b1;
      end else begin
        k_proj_nxt[i] = s[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_degen_r <= s_degen_r[NW-1];
      i_p_r     <= s_p_r[NW-1];
      i_org_r   <= s_org_r[NW-1];
      i_neg_r   <= s_neg_r[NW-1];
      i_qr_r    <= i_qr_nxt;

      j_degen_r <= i_degen_r;
      j_p_r     <= i_p_r;
      j_sum_r   <= j_sum_nxt;

      k_degen_r <= j_degen_r;
      k_sat_r   <= k_sat_nxt;
      k_proj_r  <= k_proj_nxt;
    end
  end

  // Output register plus one skid entry. The tail item goes straight to the
  // output when that is free or being taken, otherwise into the skid.
  assign push = en && k_vld_r;
  assign take = o_vld_r && out_ready;

  always_comb begin
    o_vld_nxt  = o_vld_r;
    sk_vld_nxt = sk_vld_r;
    ld_tail    = 1'b0;
    ld_skid    = 1'b0;
    sk_ld      = 1'b0;
    if (sk_vld_r) begin
      if (take) begin
        ld_skid    = 1'b1;
        sk_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!o_vld_r || take) begin
        ld_tail   = 1'b1;
        o_vld_nxt = 1'b1;
      end else begin
        sk_ld      = 1'b1;
        sk_vld_nxt = 1'b1;
      end
    end else if (take) begin
      o_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r  <= 1'b0;
      sk_vld_r <= 1'b0;
    end else begin
      o_vld_r  <= o_vld_nxt;
      sk_vld_r <= sk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_tail) begin
      o_proj_r  <= k_proj_r;
      o_degen_r <= k_degen_r;
      o_sat_r   <= k_sat_r;
    end else if (ld_skid) begin
      o_proj_r  <= sk_proj_r;
      o_degen_r <= sk_degen_r;
      o_sat_r   <= sk_sat_r;
    end
    if (sk_ld) begin
      sk_proj_r  <= k_proj_r;
      sk_degen_r <= k_degen_r;
      sk_sat_r   <= k_sat_r;
    end
  end

  assign out_valid      = o_vld_r;
  assign out_proj_x     = o_proj_r[0];
  assign out_proj_y     = o_proj_r[1];
  assign out_proj_z     = o_proj_r[2];
  assign out_degenerate = o_degen_r;
  assign out_saturated  = o_sat_r;

  // skid only ever holds the item behind the one on the output
  `POP_ASSERT_SAME(a_skid_behind_out, sk_vld_r, o_vld_r, "skid full with output empty")
  // a passed-through point is never reported as clamped
  `POP_ASSERT_SAME(a_degen_no_sat, o_vld_r && o_degen_r, !o_sat_r, "degenerate and saturated")
  // a blocked transfer at the tail must land in the skid
  `POP_ASSERT_NEXT(a_skid_catch, push && o_vld_r && !out_ready && !sk_vld_r, sk_vld_r,
                   "tail transfer lost on output stall")
  // a full skid freezes the pipeline tail
  `POP_ASSERT_NEXT(a_skid_freeze, sk_vld_r && !out_ready, sk_vld_r && $stable(k_vld_r),
                   "pipeline moved while skid full")

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the point orthogonal projection block
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import pop_pkg::*;

  localparam int CW        = 32;
  localparam int FB        = 16;
  localparam int N_RANDOM  = 700;
  localparam int DRAIN     = 200;     // wait after the last owed projection, well past the pipeline depth
  localparam int LIMIT     = 600000;  // cycle budget for the whole run
  localparam int HOLD_LEN  = 400;     // long receiver hold-off, in cycles
  localparam int HOLD_AT   = 150;     // output transfers before the hold-off
  localparam int MAX_SHOWN = 10;

  typedef logic signed [191:0] wide_t;
  typedef logic signed [CW-1:0] crd_t;

  typedef struct packed {
    act_t action;
    crd_t px, py, pz;
    crd_t va, vb, vc;
    crd_t bx, by, bz;
    crd_t d;
  } job_t;

  typedef struct packed {
    crd_t x, y, z;
    logic degen;
    logic sat;
  } proj_t;

  typedef struct packed {
    job_t  job;
    logic  typed;   // expected result written by hand in the table
    proj_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid;
  crd_t out_proj_x, out_proj_y, out_proj_z;
  logic out_degenerate, out_saturated;

  // item on offer; the input ports read straight from it
  row_t offer = '0;

  row_t  stim_q[$];
  proj_t proj_q[$];      // projections still owed by the block
  int    errors = 0;
  int    cycles = 0;
  int    out_count = 0;
  logic  sender_burst = 1'b0;   // stretch with no idling on either side

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  point_orthogonal_projection #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(offer.job.action),
    .in_pt_x(offer.job.px), .in_pt_y(offer.job.py), .in_pt_z(offer.job.pz),
    .in_vec_a(offer.job.va), .in_vec_b(offer.job.vb), .in_vec_c(offer.job.vc),
    .in_base_x(offer.job.bx), .in_base_y(offer.job.by), .in_base_z(offer.job.bz),
    .in_plane_offset(offer.job.d),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_proj_x(out_proj_x), .out_proj_y(out_proj_y), .out_proj_z(out_proj_z),
    .out_degenerate(out_degenerate), .out_saturated(out_saturated)
  );

  function automatic wide_t widen(input crd_t c);
    widen = $signed({{(192-CW){c[CW-1]}}, c});
  endfunction

  // exact n/d rounded to nearest, ties away from zero; d > 0
  function automatic wide_t div_round(input wide_t n, input wide_t d);
    wide_t m, q, r;
    m = (n < 0) ? -n : n;
    q = m / d;
    r = m - q * d;
    if (2 * r >= d) q = q + 1;
    div_round = (n < 0) ? -q : q;
  endfunction

  function automatic crd_t clamp_coord(input wide_t v, inout logic sat);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (CW - 1)) - 1;
    lo = -(wide_t'(1) <<< (CW - 1));
    if (v > hi) begin
      sat = 1'b1;
      v = hi;
    end else if (v < lo) begin
      sat = 1'b1;
      v = lo;
    end
    clamp_coord = v[CW-1:0];
  endfunction

  // project the point onto the line or plane that the job describes
  function automatic proj_t project(input job_t j);
    wide_t p[3], v[3], o[3], num, den;
    proj_t r;
    logic  sat;
    crd_t  c[3];
    p[0] = widen(j.px); p[1] = widen(j.py); p[2] = widen(j.pz);
    v[0] = widen(j.va); v[1] = widen(j.vb); v[2] = widen(j.vc);
    den = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    r = '0;
    if (den == 0) begin
      r.x = j.px; r.y = j.py; r.z = j.pz;
      r.degen = 1'b1;
      return r;
    end
    if (j.action == ACT_PLANE) begin
      num = -(v[0] * p[0] + v[1] * p[1] + v[2] * p[2] + (widen(j.d) <<< FB));
      o = p;
    end else begin
      o[0] = widen(j.bx); o[1] = widen(j.by); o[2] = widen(j.bz);
      num = v[0] * (p[0] - o[0]) + v[1] * (p[1] - o[1]) + v[2] * (p[2] - o[2]);
    end
    sat = 1'b0;
    for (int i = 0; i < 3; i++)
      c[i] = clamp_coord(o[i] + div_round(v[i] * num, den), sat);
    r.x = c[0]; r.y = c[1]; r.z = c[2];
    r.sat = sat;
    return r;
  endfunction

  // coordinate mix: full range, small raw values, small integers, extremes
  function automatic crd_t rand_coord();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return crd_t'($urandom);
    if (k < 70) return crd_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
    if (k < 85) return crd_t'(($signed($urandom_range(0, 200)) - 100) <<< FB);
    if (k < 93) begin
      case ($urandom_range(0, 3))
        0: return {1'b0, {(CW-1){1'b1}}};
        1: return {1'b1, {(CW-1){1'b0}}};
        2: return '0;
        default: return '1;
      endcase
    end
    return crd_t'($urandom_range(0, 32'h7fffffff)) ^ {2'b01, {(CW-2){1'b0}}};
  endfunction

  function automatic job_t rand_job();
    job_t j;
    j.action = act_t'($urandom_range(0, 1));
    j.px = rand_coord(); j.py = rand_coord(); j.pz = rand_coord();
    j.va = rand_coord(); j.vb = rand_coord(); j.vc = rand_coord();
    j.bx = rand_coord(); j.by = rand_coord(); j.bz = rand_coord();
    j.d  = rand_coord();
    if ($urandom_range(0, 99) < 6) begin
      j.va = '0; j.vb = '0; j.vc = '0;
    end
    return j;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int rand_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(input job_t j, input logic typed, input proj_t want);
    row_t r;
    r.job = j;
    r.typed = typed;
    r.want = want;
    stim_q.push_back(r);
  endtask

  function automatic job_t mk(input act_t a, input crd_t px, py, pz, va, vb, vc,
                              input crd_t bx, by, bz, d);
    mk = '{a, px, py, pz, va, vb, vc, bx, by, bz, d};
  endfunction

  function automatic proj_t pr(input crd_t x, y, z, input logic dg, st);
    pr = '{x, y, z, dg, st};
  endfunction

  task automatic build_table();
    crd_t mx, mn, one;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    one = crd_t'(1) <<< FB;
    // zero-length vector: point passes through in either mode
    add_row(mk(ACT_LINE, mx, mn, 7, 0, 0, 0, 1, 2, 3, 4), 1'b1,
            pr(mx, mn, 7, 1'b1, 1'b0));
    add_row(mk(ACT_PLANE, mn, mx, -1, 0, 0, 0, 5, 5, 5, mx), 1'b1,
            pr(mn, mx, -1, 1'b1, 1'b0));
    // unit direction along x, base at origin
    add_row(mk(ACT_LINE, 5, 7, 9, one, 0, 0, 0, 0, 0, 0), 1'b1,
            pr(5, 0, 0, 1'b0, 1'b0));
    // unit normal along z, plane through origin
    add_row(mk(ACT_PLANE, 1, 2, 3, 0, 0, one, 0, 0, 0, 0), 1'b1,
            pr(1, 2, 0, 1'b0, 1'b0));
    // plane x = -d with d at its minimum lands past the top and clamps
    add_row(mk(ACT_PLANE, mx, 0, 0, one, 0, 0, 0, 0, 0, mn), 1'b1,
            pr(mx, 0, 0, 1'b0, 1'b1));
    // rounding ties go away from zero
    add_row(mk(ACT_LINE, 1, 0, 0, 1, 1, 0, 0, 0, 0, 0), 1'b1,
            pr(1, 1, 0, 1'b0, 1'b0));
    add_row(mk(ACT_LINE, -1, 0, 0, 1, 1, 0, 0, 0, 0, 0), 1'b1,
            pr(-1, -1, 0, 1'b0, 1'b0));
    // extremes left to the predictor
    add_row(mk(ACT_LINE, mx, mx, mx, mx, mx, mx, mn, mn, mn, 0), 1'b0, '0);
    add_row(mk(ACT_LINE, mn, mn, mn, mn, mn, mn, mx, mx, mx, 0), 1'b0, '0);
    add_row(mk(ACT_LINE, mx, mn, mx, 1, 0, 0, mn, mx, mn, mx), 1'b0, '0);
    add_row(mk(ACT_PLANE, mx, mx, mx, mx, mx, mx, 0, 0, 0, mx), 1'b0, '0);
    add_row(mk(ACT_PLANE, mn, mn, mn, mn, mn, mn, 0, 0, 0, mn), 1'b0, '0);
    add_row(mk(ACT_PLANE, mx, mn, 0, 1, 0, 0, mx, mx, mx, mx), 1'b0, '0);
    add_row(mk(ACT_PLANE, mn, 0, 0, -one, 0, 0, 0, 0, 0, mx), 1'b0, '0);
    add_row(mk(ACT_PLANE, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b0, '0);
    add_row(mk(ACT_LINE, 0, 0, 0, mn, 0, 0, mx, mx, mx, 0), 1'b0, '0);
    add_row(mk(ACT_PLANE, 0, 0, 0, 0, 0, 1, 0, 0, 0, -1), 1'b0, '0);
  endtask

  // input side: record the owed projection at every accepted transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      proj_q.push_back(offer.typed ? offer.want : project(offer.job));
  end

  // output side: compare every accepted transfer with the oldest owed projection
  always @(posedge clk) begin
    proj_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_proj_x, out_proj_y, out_proj_z, out_degenerate, out_saturated};
      out_count <= out_count + 1;
      if (proj_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < MAX_SHOWN)
          $display("unexpected output transfer: %h %h %h deg=%b sat=%b",
                   got.x, got.y, got.z, got.degen, got.sat);
      end else begin
        want = proj_q.pop_front();
        if (got !== want) begin
          errors <= errors + 1;
          if (errors < MAX_SHOWN)
            $display("mismatch: exp %h %h %h deg=%b sat=%b, got %h %h %h deg=%b sat=%b",
                     want.x, want.y, want.z, want.degen, want.sat,
                     got.x, got.y, got.z, got.degen, got.sat);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL point_orthogonal_projection");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    int stall;
    logic held;
    stall = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && out_count >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!sender_burst) stall = rand_gap();
      end
    end
  end

  // sender and run control
  initial begin
    row_t r;
    int   gap;
    build_table();
    for (int i = 0; i < N_RANDOM; i++) begin
      r.job = rand_job();
      r.typed = 1'b0;
      r.want = '0;
      stim_q.push_back(r);
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < stim_q.size(); i++) begin
      sender_burst = (i >= 400 && i < 480);
      gap = sender_burst ? 0 : rand_gap();
      @(negedge clk);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      offer <= stim_q[i];
      in_valid <= 1'b1;
      do @(posedge clk); while (!in_ready);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    sender_burst = 1'b0;
    while (proj_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("PASS point_orthogonal_projection");
    end else begin
      $display("FAIL point_orthogonal_projection");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+src
src/pop_pkg.sv
src/pop_div.sv
src/point_orthogonal_projection.sv
bench/testbench.sv
